[design/aabb_screen_rect_projection_defines.svh]
// assertion macros shared by the checker
`ifndef AABB_SCREEN_RECT_PROJECTION_DEFINES_SVH
`define AABB_SCREEN_RECT_PROJECTION_DEFINES_SVH
// implication checked on every clock edge outside reset
`define ASRP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// implication checked on every clock edge, reset included
`define ASRP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[design/asrp_pkg.sv]
// shared types and constants for the box projection block
package asrp_pkg;
   localparam int CoefW = 16;
   localparam int CoordW = 32;
   localparam int ProdW = 49;
   localparam int DotW = 52;
   localparam int QuoW = 16;
   localparam int DepthW = 31;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 64;
   localparam int NumCorners = 8;
   localparam int DivSteps = 64;
   localparam logic signed [QuoW-1:0] QOne = 16'sd4096;
   localparam logic signed [QuoW-1:0] QMax = 16'sh7fff;
   localparam logic signed [QuoW-1:0] QMin = -16'sh8000;
   localparam logic [DepthW-1:0] DepthStraddle = 31'd7;
   localparam logic [DepthW-1:0] DepthMax = 31'h7fffffff;

   typedef enum logic [CsrIdxW-1:0] {
      REG_ROW0 = 2'd0,
      REG_ROW1 = 2'd1,
      REG_ROW2 = 2'd2,
      REG_ROW3 = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic front;
      logic in_view;
      logic signed [QuoW-1:0] qx;
      logic signed [QuoW-1:0] qy;
      logic [DotW-1:0] w;
   } corner_type;
endpackage

[design/asrp_corner.sv]
// one corner lane: transform, then pipelined restoring divide of x and y by w
module asrp_corner (
   input  logic clock,
   input  logic advance,
   input  logic signed [asrp_pkg::CoordW-1:0] px,
   input  logic signed [asrp_pkg::CoordW-1:0] py,
   input  logic signed [asrp_pkg::CoordW-1:0] pz,
   input  logic [asrp_pkg::CsrDataW-1:0] row0,
   input  logic [asrp_pkg::CsrDataW-1:0] row1,
   input  logic [asrp_pkg::CsrDataW-1:0] row3,
   output asrp_pkg::corner_type result
);
   localparam int DivSteps = asrp_pkg::DivSteps;
   localparam int PW = asrp_pkg::ProdW;
   localparam int DW = asrp_pkg::DotW;
   // dividend |x|*4096 fits in 64 bits, quotient saturates past 16 bits
   localparam int NW = 64;
   localparam int RW = DW + 1;

   // stage 1: twelve products
   logic signed [PW-1:0] prod_ff [3][4];
   // stage 2: dot products
   logic signed [DW-1:0] x_ff, y_ff, w_ff;
   // divider pipeline (two dividers, x and y)
   logic [NW-1:0] nx_ff [DivSteps+1];
   logic [NW-1:0] ny_ff [DivSteps+1];
   logic [RW-1:0] rx_ff [DivSteps+1];
   logic [RW-1:0] ry_ff [DivSteps+1];
   logic [DW-1:0] d_ff [DivSteps+1];
   logic sx_ff [DivSteps+1];
   logic sy_ff [DivSteps+1];
   logic f_ff [DivSteps+1];
   logic in_ff [DivSteps+1];
   logic [DW-1:0] wq_ff [DivSteps+1];
   logic [asrp_pkg::CsrDataW-1:0] rows [3];

   assign rows[0] = row0;
   assign rows[1] = row1;
   assign rows[2] = row3;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[r][0] <= PW'($signed(rows[r][15:0]) * px);
            prod_ff[r][1] <= PW'($signed(rows[r][31:16]) * py);
            prod_ff[r][2] <= PW'($signed(rows[r][47:32]) * pz);
            prod_ff[r][3] <= PW'({{(PW-32){rows[r][63]}}, rows[r][63:48], 16'd0});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= DW'(prod_ff[0][0]) + DW'(prod_ff[0][1]) + DW'(prod_ff[0][2])
            + DW'(prod_ff[0][3]);
         y_ff <= DW'(prod_ff[1][0]) + DW'(prod_ff[1][1]) + DW'(prod_ff[1][2])
            + DW'(prod_ff[1][3]);
         w_ff <= DW'(prod_ff[2][0]) + DW'(prod_ff[2][1]) + DW'(prod_ff[2][2])
            + DW'(prod_ff[2][3]);
      end
   end

   logic [DW-1:0] ax, ay;
   logic front0, inside0;
   assign ax = x_ff[DW-1] ? DW'(-x_ff) : DW'(x_ff);
   assign ay = y_ff[DW-1] ? DW'(-y_ff) : DW'(y_ff);
   assign front0 = !w_ff[DW-1] && (w_ff != '0);
   assign inside0 = front0 && (ax <= w_ff) && (ay <= w_ff);

   // step 0 loads, steps 1..DivSteps each take one quotient bit
   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff[0] <= {ax, 12'd0};
         ny_ff[0] <= {ay, 12'd0};
         rx_ff[0] <= '0;
         ry_ff[0] <= '0;
         d_ff[0] <= w_ff;
         sx_ff[0] <= x_ff[DW-1];
         sy_ff[0] <= y_ff[DW-1];
         f_ff[0] <= front0;
         in_ff[0] <= inside0;
         wq_ff[0] <= w_ff;
      end
   end

   for (genvar s = 1; s <= DivSteps; s++) begin : g_div
      logic [RW-1:0] tx, ty;
      assign tx = {rx_ff[s-1][RW-2:0], nx_ff[s-1][NW-1]};
      assign ty = {ry_ff[s-1][RW-2:0], ny_ff[s-1][NW-1]};
      always_ff @(posedge clock) begin
         if (advance) begin
            if (tx >= {1'b0, d_ff[s-1]}) begin
               rx_ff[s] <= tx - {1'b0, d_ff[s-1]};
               nx_ff[s] <= {nx_ff[s-1][NW-2:0], 1'b1};
            end else begin
               rx_ff[s] <= tx;
               nx_ff[s] <= {nx_ff[s-1][NW-2:0], 1'b0};
            end
            if (ty >= {1'b0, d_ff[s-1]}) begin
               ry_ff[s] <= ty - {1'b0, d_ff[s-1]};
               ny_ff[s] <= {ny_ff[s-1][NW-2:0], 1'b1};
            end else begin
               ry_ff[s] <= ty;
               ny_ff[s] <= {ny_ff[s-1][NW-2:0], 1'b0};
            end
            d_ff[s] <= d_ff[s-1];
            sx_ff[s] <= sx_ff[s-1];
            sy_ff[s] <= sy_ff[s-1];
            f_ff[s] <= f_ff[s-1];
            in_ff[s] <= in_ff[s-1];
            wq_ff[s] <= wq_ff[s-1];
         end
      end
   end

   function automatic logic signed [asrp_pkg::QuoW-1:0] sat_q(
      input logic [NW-1:0] mag, input logic neg);
      logic signed [asrp_pkg::QuoW-1:0] r;
      if (neg) r = (mag > 64'd32768) ? asrp_pkg::QMin : asrp_pkg::QuoW'(-mag);
      else r = (mag > 64'd32767) ? asrp_pkg::QMax : asrp_pkg::QuoW'(mag);
      return r;
   endfunction

   // last shift register holds quotient bits only after NW steps
   assign result.front = f_ff[DivSteps];
   assign result.in_view = in_ff[DivSteps];
   assign result.qx = sat_q(nx_ff[DivSteps], sx_ff[DivSteps]);
   assign result.qy = sat_q(ny_ff[DivSteps], sy_ff[DivSteps]);
   assign result.w = wq_ff[DivSteps];
endmodule

[design/aabb_screen_rect_projection.sv]
// top level: projected screen rectangle of an axis-aligned box
// pipeline: products, dot sums, divider load, divide steps, merge stages, output register
// throughput: one box per cycle while the output is not stalled, eight corner lanes run side by side
// the 64-step restoring divider pipeline of each lane sets the latency
// reset clears valid bits and the matrix rows; payload registers are not reset
// stall freezes the whole pipeline, so no item is lost or repeated
module aabb_screen_rect_projection (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_max_z,
   input  logic csr_write,
   input  logic [asrp_pkg::CsrIdxW-1:0] csr_index,
   input  logic [asrp_pkg::CsrDataW-1:0] csr_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_has_front,
   output logic rsp_in_frustum,
   output logic signed [15:0] rsp_rect_x_lo,
   output logic signed [15:0] rsp_rect_y_lo,
   output logic signed [15:0] rsp_rect_x_hi,
   output logic signed [15:0] rsp_rect_y_hi,
   output logic [30:0] rsp_nearest_depth
);
   // lane pipeline: 1 product + 1 sum + 1 load + 64 divide steps
   localparam int DivSteps = asrp_pkg::DivSteps;
   localparam int LanePipe = DivSteps + 3;
   localparam int DW = asrp_pkg::DotW;

   logic [asrp_pkg::CsrDataW-1:0] row_ff [4];

   // matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) row_ff[i] <= '0;
      end else if (csr_write) begin
         case (asrp_pkg::reg_idx_type'(csr_index))
            asrp_pkg::REG_ROW0: row_ff[0] <= csr_data;
            asrp_pkg::REG_ROW1: row_ff[1] <= csr_data;
            asrp_pkg::REG_ROW2: row_ff[2] <= csr_data;
            asrp_pkg::REG_ROW3: row_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output slot is free or empty
   logic advance;
   logic out_valid_ff;
   assign advance = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // valid bits through the lanes plus merge stages
   logic vld_ff [LanePipe + 2];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LanePipe + 2; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LanePipe + 2; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   asrp_pkg::corner_type cr [asrp_pkg::NumCorners];

   for (genvar c = 0; c < asrp_pkg::NumCorners; c++) begin : g_lane
      asrp_corner u_corner (
         .clock(clock),
         .advance(advance),
         .px(c[0] ? req_box_max_x : req_box_min_x),
         .py(c[1] ? req_box_max_y : req_box_min_y),
         .pz(c[2] ? req_box_max_z : req_box_min_z),
         .row0(row_ff[0]),
         .row1(row_ff[1]),
         .row3(row_ff[3]),
         .result(cr[c])
      );
   end

   // merge stage 1: pairs of corners
   typedef struct packed {
      logic front;
      logic behind;
      logic in_view;
      logic signed [15:0] xl, xh, yl, yh;
      logic [DW-1:0] wmin;
   } acc_type;

   function automatic acc_type leaf(input asrp_pkg::corner_type c);
      acc_type a;
      a.front = c.front;
      a.behind = !c.front;
      a.in_view = c.in_view;
      a.xl = c.front ? c.qx : asrp_pkg::QMax;
      a.xh = c.front ? c.qx : asrp_pkg::QMin;
      a.yl = c.front ? c.qy : asrp_pkg::QMax;
      a.yh = c.front ? c.qy : asrp_pkg::QMin;
      a.wmin = c.front ? c.w : {1'b0, {(DW-1){1'b1}}};
      return a;
   endfunction

   function automatic acc_type join2(input acc_type a, input acc_type b);
      acc_type r;
      r.front = a.front | b.front;
      r.behind = a.behind | b.behind;
      r.in_view = a.in_view | b.in_view;
      r.xl = (a.xl < b.xl) ? a.xl : b.xl;
      r.xh = (a.xh > b.xh) ? a.xh : b.xh;
      r.yl = (a.yl < b.yl) ? a.yl : b.yl;
      r.yh = (a.yh > b.yh) ? a.yh : b.yh;
      r.wmin = (a.wmin < b.wmin) ? a.wmin : b.wmin;
      return r;
   endfunction

   acc_type m1_ff [4];
   acc_type m2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) m1_ff[i] <= join2(leaf(cr[2*i]), leaf(cr[2*i+1]));
         m2_ff <= join2(join2(m1_ff[0], m1_ff[1]), join2(m1_ff[2], m1_ff[3]));
      end
   end

   // final formatting into output register
   logic [DW-1:0] depth_wide;
   assign depth_wide = m2_ff.wmin >> 12;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[LanePipe + 1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (!m2_ff.front) begin
            rsp_has_front <= 1'b0;
            rsp_in_frustum <= 1'b0;
            rsp_rect_x_lo <= '0;
            rsp_rect_y_lo <= '0;
            rsp_rect_x_hi <= '0;
            rsp_rect_y_hi <= '0;
            rsp_nearest_depth <= '0;
         end else if (m2_ff.behind) begin
            rsp_has_front <= 1'b1;
            rsp_in_frustum <= m2_ff.in_view;
            rsp_rect_x_lo <= -asrp_pkg::QOne;
            rsp_rect_y_lo <= -asrp_pkg::QOne;
            rsp_rect_x_hi <= asrp_pkg::QOne;
            rsp_rect_y_hi <= asrp_pkg::QOne;
            rsp_nearest_depth <= asrp_pkg::DepthStraddle;
         end else begin
            rsp_has_front <= 1'b1;
            rsp_in_frustum <= m2_ff.in_view;
            rsp_rect_x_lo <= m2_ff.xl;
            rsp_rect_y_lo <= m2_ff.yl;
            rsp_rect_x_hi <= m2_ff.xh;
            rsp_rect_y_hi <= m2_ff.yh;
            rsp_nearest_depth <= (depth_wide > DW'(asrp_pkg::DepthMax))
               ? asrp_pkg::DepthMax : depth_wide[30:0];
         end
      end
   end

   assign rsp_valid = out_valid_ff;
endmodule

[design/asrp_checker.sv]
// port checker for the box projection block, bound to the top level
`include "aabb_screen_rect_projection_defines.svh"
module asrp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_has_front,
   input logic rsp_in_frustum,
   input logic [15:0] rsp_rect_x_lo,
   input logic [30:0] rsp_nearest_depth
);
   `ASRP_ASSERT(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rect_x_lo), "result dropped under stall")
   `ASRP_ASSERT(a_nofront, clock, reset, rsp_valid && !rsp_has_front |-> !rsp_in_frustum && rsp_nearest_depth == 31'd0, "no-front result not cleared")
   `ASRP_ASSERT(a_stall, clock, reset, req_stall |-> rsp_valid && rsp_stall, "input stalled without output back-pressure")
   `ASRP_ASSERT_ALWAYS(a_reset, clock, reset |=> !rsp_valid, "result valid after reset")
endmodule

bind aabb_screen_rect_projection asrp_checker u_asrp_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_has_front(rsp_has_front),
   .rsp_in_frustum(rsp_in_frustum),
   .rsp_rect_x_lo(rsp_rect_x_lo),
   .rsp_nearest_depth(rsp_nearest_depth)
);

[sim/tb_top.sv]
// testbench for the box projection block: directed tables plus random boxes
`timescale 1ns / 100ps

module tb_top;

   // one box as driven on the request side
   typedef struct packed {
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] min_z;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
      logic signed [31:0] max_z;
   } box_type;

   // one projected rectangle as seen on the response side
   typedef struct packed {
      logic has_front;
      logic in_frustum;
      logic signed [15:0] x_lo;
      logic signed [15:0] y_lo;
      logic signed [15:0] x_hi;
      logic signed [15:0] y_hi;
      logic [30:0] depth;
   } rect_type;

   // a directed row: typed rows carry their rectangle, the rest are predicted
   typedef struct packed {
      logic typed;
      box_type box;
      rect_type rect;
   } box_row_type;

   localparam logic signed [31:0] SMax = 32'sh7fffffff;
   localparam logic signed [31:0] SMin = 32'sh80000000;
   localparam logic signed [31:0] One = 32'sh00010000;
   localparam int LimitCycles = 400000;
   localparam int DrainCycles = 90;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   box_type req_box = '0;
   logic csr_write = 1'b0;
   logic [asrp_pkg::CsrIdxW-1:0] csr_index = asrp_pkg::REG_ROW0;
   logic [asrp_pkg::CsrDataW-1:0] csr_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rect_type rsp_rect;

   logic [63:0] matrix_rows [4];
   rect_type pending_rects [$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int cycle_count = 0;

   aabb_screen_rect_projection dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_box_min_x(req_box.min_x),
      .req_box_min_y(req_box.min_y),
      .req_box_min_z(req_box.min_z),
      .req_box_max_x(req_box.max_x),
      .req_box_max_y(req_box.max_y),
      .req_box_max_z(req_box.max_z),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_has_front(rsp_rect.has_front),
      .rsp_in_frustum(rsp_rect.in_frustum),
      .rsp_rect_x_lo(rsp_rect.x_lo),
      .rsp_rect_y_lo(rsp_rect.y_lo),
      .rsp_rect_x_hi(rsp_rect.x_hi),
      .rsp_rect_y_hi(rsp_rect.y_hi),
      .rsp_nearest_depth(rsp_rect.depth)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // matrix coefficient, signed q4.12
   function automatic longint coef(int r, int c);
      logic signed [15:0] t;
      t = matrix_rows[r][16*c +: 16];
      return longint'(t);
   endfunction

   // one row of the matrix against a corner, result in q.28
   function automatic longint row_dot(int r, longint px, longint py, longint pz);
      return coef(r, 0) * px + coef(r, 1) * py + coef(r, 2) * pz + coef(r, 3) * 65536;
   endfunction

   function automatic longint clamp_q412(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   // screen rectangle of a box under the current matrix
   function automatic rect_type project_box(box_type b);
      longint px, py, pz, x, y, w, qx, qy, wmin, dep;
      longint xl, yl, xh, yh;
      bit front, behind, in_view;
      rect_type r;
      xl = 32767; yl = 32767; xh = -32768; yh = -32768;
      wmin = 0; front = 0; behind = 0; in_view = 0;
      for (int c = 0; c < asrp_pkg::NumCorners; c++) begin
         px = c[0] ? longint'(b.max_x) : longint'(b.min_x);
         py = c[1] ? longint'(b.max_y) : longint'(b.min_y);
         pz = c[2] ? longint'(b.max_z) : longint'(b.min_z);
         x = row_dot(0, px, py, pz);
         y = row_dot(1, px, py, pz);
         w = row_dot(3, px, py, pz);
         if (w > 0) begin
            qx = clamp_q412((x * 4096) / w);
            qy = clamp_q412((y * 4096) / w);
            if (!front || w < wmin) wmin = w;
            front = 1;
            if (qx < xl) xl = qx;
            if (qx > xh) xh = qx;
            if (qy < yl) yl = qy;
            if (qy > yh) yh = qy;
            if (mag(x) <= w && mag(y) <= w) in_view = 1;
         end else begin
            behind = 1;
         end
      end
      r = '0;
      if (!front) return r;
      if (behind) begin
         // straddles the eye plane: full screen, tiny depth
         xl = -4096; yl = -4096; xh = 4096; yh = 4096;
         dep = 7;
      end else begin
         dep = wmin >>> 12;
         if (dep > 64'h7fffffff) dep = 64'h7fffffff;
      end
      r.has_front = 1'b1;
      r.in_frustum = in_view;
      r.x_lo = xl[15:0];
      r.y_lo = yl[15:0];
      r.x_hi = xh[15:0];
      r.y_hi = yh[15:0];
      r.depth = dep[30:0];
      return r;
   endfunction

   // write all four rows, only while the block is empty
   task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                              logic [63:0] r3);
      logic [63:0] vals [4];
      vals = '{r0, r1, r2, r3};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= asrp_pkg::reg_idx_type'(i);
         csr_data <= vals[i];
         matrix_rows[i] = vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // offer one item, recording what should come back
   task automatic send_box(box_type b, bit typed, rect_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_box <= b;
      pending_rects.insert(pending_rects.size(), typed ? want : project_box(b));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_coef;
      case ($urandom_range(5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($urandom());
         default: return 16'($signed($urandom_range(8192)) - 4096);
      endcase
   endfunction

   function automatic logic [63:0] rand_row(bit w_row);
      logic [63:0] r;
      r = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      // w row mostly pushes the box in front of the eye
      if (w_row && $urandom_range(3) != 0) r[63:48] = 16'($urandom_range(32767, 256));
      return r;
   endfunction

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return 32'($signed($urandom_range(262144)) - 131072);
         1: return 32'($signed($urandom_range(16777216)) - 8388608);
         2: return 32'($urandom());
         default: begin
            case ($urandom_range(2))
               0: return SMax;
               1: return SMin;
               default: return '0;
            endcase
         end
      endcase
   endfunction

   function automatic box_type rand_box;
      box_type b;
      int mode;
      int pick;
      pick = $urandom_range(9);
      mode = pick < 6 ? 0 : pick < 8 ? 1 : pick == 8 ? 2 : 3;
      b.min_x = rand_coord(mode);
      b.min_y = rand_coord(mode);
      b.min_z = rand_coord(mode);
      b.max_x = rand_coord(mode);
      b.max_y = rand_coord(mode);
      b.max_z = rand_coord(mode);
      // mostly well-ordered boxes, sometimes inverted ones left as they are
      if ($urandom_range(4) != 0) begin
         if (b.min_x > b.max_x) {b.min_x, b.max_x} = {b.max_x, b.min_x};
         if (b.min_y > b.max_y) {b.min_y, b.max_y} = {b.max_y, b.min_y};
         if (b.min_z > b.max_z) {b.min_z, b.max_z} = {b.max_z, b.min_z};
      end
      return b;
   endfunction

   // zero matrix: every w is zero, so nothing is in front
   box_row_type zero_rows [5] = '{
      '{1'b1, '{SMin, SMin, SMin, SMax, SMax, SMax}, '0},
      '{1'b1, '{SMax, SMax, SMax, SMin, SMin, SMin}, '0},
      '{1'b1, '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, '0},
      '{1'b1, '{-32'sh1, -32'sh1, -32'sh1, 32'sh1, 32'sh1, 32'sh1}, '0},
      '{1'b1, '{32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 32'shf0f0f0f0,
                32'sh33333333, 32'shcccccccc}, '0}
   };

   // w = z, x = y = 0: a box through z = 0 straddles the eye plane
   box_row_type wz_rows [5] = '{
      '{1'b1, '{-One, -One, -One, One, One, One},
        '{1'b1, 1'b1, -16'sd4096, -16'sd4096, 16'sd4096, 16'sd4096, 31'd7}},
      '{1'b1, '{SMin, SMin, SMin, SMax, SMax, SMax},
        '{1'b1, 1'b1, -16'sd4096, -16'sd4096, 16'sd4096, 16'sd4096, 31'd7}},
      '{1'b1, '{SMin, SMin, SMin, SMax, SMax, -One}, '0},
      '{1'b1, '{SMax, SMax, One, SMin, SMin, One},
        '{1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 31'h10000}},
      '{1'b0, '{SMin, SMin, SMax, SMax, SMax, SMax}, '0}
   };

   // plain perspective: x, y passed through, w = z, checked by prediction
   box_row_type persp_rows [8] = '{
      '{1'b0, '{-One, -One, One, One, One, 32'sh20000}, '0},
      '{1'b0, '{32'sh100, 32'sh100, 32'sh1, 32'sh200, 32'sh200, 32'sh2}, '0},
      '{1'b0, '{SMin, SMin, 32'sh1, SMax, SMax, 32'sh1}, '0},
      '{1'b0, '{SMin, SMin, SMax, SMax, SMax, SMax}, '0},
      '{1'b0, '{-One, -One, -One, One, One, 32'sh8000}, '0},
      '{1'b0, '{32'sh30000, 32'sh30000, One, 32'sh40000, 32'sh40000, One}, '0},
      '{1'b0, '{One, One, One, -One, -One, 32'sh18000}, '0},
      '{1'b0, '{-32'sh30000, 32'sh0, One, 32'sh0, 32'sh30000, 32'sh10000}, '0}
   };

   // response side: check in order, then pick next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rects.size() == 0) begin
            $error("rectangle arrived with none outstanding");
            fail_count++;
         end else begin
            rect_type want;
            want = pending_rects.pop_front();
            if (rsp_rect.has_front !== want.has_front) begin
               $error("has_front: expected %0d actual %0d", want.has_front,
                      rsp_rect.has_front);
               fail_count++;
            end
            if (rsp_rect.in_frustum !== want.in_frustum) begin
               $error("in_frustum: expected %0d actual %0d", want.in_frustum,
                      rsp_rect.in_frustum);
               fail_count++;
            end
            if (rsp_rect.x_lo !== want.x_lo) begin
               $error("rect_x_lo: expected %0d actual %0d", want.x_lo, rsp_rect.x_lo);
               fail_count++;
            end
            if (rsp_rect.y_lo !== want.y_lo) begin
               $error("rect_y_lo: expected %0d actual %0d", want.y_lo, rsp_rect.y_lo);
               fail_count++;
            end
            if (rsp_rect.x_hi !== want.x_hi) begin
               $error("rect_x_hi: expected %0d actual %0d", want.x_hi, rsp_rect.x_hi);
               fail_count++;
            end
            if (rsp_rect.y_hi !== want.y_hi) begin
               $error("rect_y_hi: expected %0d actual %0d", want.y_hi, rsp_rect.y_hi);
               fail_count++;
            end
            if (rsp_rect.depth !== want.depth) begin
               $error("nearest_depth: expected %0d actual %0d", want.depth,
                      rsp_rect.depth);
               fail_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LimitCycles) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int idle_modes [4][2];
      idle_modes = '{'{0, 0}, '{84, 0}, '{0, 84}, '{9, 9}};
      for (int i = 0; i < 4; i++) matrix_rows[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // matrix still at reset value
      foreach (zero_rows[i]) send_box(zero_rows[i].box, zero_rows[i].typed, zero_rows[i].rect);
      drain;

      load_matrix(64'h0, 64'h0, 64'h0, {16'h0, 16'h1000, 16'h0, 16'h0});
      foreach (wz_rows[i]) send_box(wz_rows[i].box, wz_rows[i].typed, wz_rows[i].rect);
      drain;

      // only a translation in w: every corner at the same depth
      load_matrix(64'h0, 64'h0, 64'h0, {16'h1000, 16'h0, 16'h0, 16'h0});
      send_box('{SMin, SMin, SMin, SMax, SMax, SMax}, 1'b1,
               '{1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 31'h10000});
      drain;

      load_matrix({48'h0, 16'h1000}, {32'h0, 16'h1000, 16'h0}, 64'h0,
                  {16'h0, 16'h1000, 32'h0});
      foreach (persp_rows[i]) send_box(persp_rows[i].box, 1'b0, '0);
      drain;

      // random matrices, extremes among them, under each idling pattern
      for (int seg = 0; seg < 16; seg++) begin
         send_idle_pct = idle_modes[seg % 4][0];
         recv_stall_pct = idle_modes[seg % 4][1];
         case (seg)
            4: load_matrix('1, '1, '1, '1);
            5: load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
            6: load_matrix({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
            default: load_matrix(rand_row(0), rand_row(0), rand_row(0), rand_row(1));
         endcase
         for (int n = 0; n < 83; n++) send_box(rand_box(), 1'b0, '0);
         drain;
      end

      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/asrp_pkg.sv
design/asrp_corner.sv
design/aabb_screen_rect_projection.sv
design/asrp_checker.sv
sim/tb_top.sv
